// ===== src/psdc_pkg.sv =====
// ----------------------------------------------------------------------------
// psdc_pkg
// Shared types, constants and lookup tables for the signature digest checker.
// ----------------------------------------------------------------------------
package psdc_pkg;

  localparam int DEF_MAX_DIGEST_BYTES = 64;

  localparam int TAIL_W = 10;
  localparam logic [TAIL_W-1:0] TAIL_MAX = 10'd1023;

  localparam logic [1:0] HASH_KIND_RST = 2'd1;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_NO_END    = 3'd2;
  localparam logic [2:0] ST_LENGTH    = 3'd3;
  localparam logic [2:0] ST_INFO      = 3'd4;
  localparam logic [2:0] ST_DIGEST    = 3'd5;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MSG  = 1'b1;

  // marker bytes
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_TYPE_1 = 8'h01;
  localparam logic [7:0] BYTE_TYPE_2 = 8'h02;

  typedef enum logic [4:0] {
    PH_FIRST = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_FILL  = 5'b00100,
    PH_TAIL  = 5'b01000,
    PH_BAD   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
  } result_t;

  localparam logic [7:0] PREFIX_ROM [4][19] = '{
    '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
      8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
    '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
    '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
  };

  function automatic logic [7:0] prefix_byte(input logic [1:0] kind,
                                             input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 5'd19) begin
      b = PREFIX_ROM[kind][idx];
    end
    return b;
  endfunction

  function automatic logic [4:0] prefix_len(input logic [1:0] kind);
    logic [4:0] n;
    case (kind)
      2'd0:    n = 5'd15;
      default: n = 5'd19;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] hash_bytes(input logic [1:0] kind);
    logic [6:0] n;
    case (kind)
      2'd0:    n = 7'h14;
      2'd1:    n = 7'h20;
      2'd2:    n = 7'h30;
      2'd3:    n = 7'h40;
      default: n = 7'h20;
    endcase
    return n;
  endfunction

endpackage

// ===== src/psdc_ram.sv =====
// ----------------------------------------------------------------------------
// psdc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/psdc_parse.sv =====
// ----------------------------------------------------------------------------
// psdc_parse
// Parse state, digest load index and status decision for one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module psdc_parse
  import psdc_pkg::*;
#(
  parameter int MAX_DIGEST_BYTES = DEF_MAX_DIGEST_BYTES,
  parameter int AW  = $clog2(MAX_DIGEST_BYTES),
  parameter int LIW = $clog2(MAX_DIGEST_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  item_t         item,
  input  logic [1:0]    hash_kind,
  input  logic [7:0]    rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic [AW-1:0] rd_addr,
  output result_t       result
);

  localparam logic [LIW-1:0]    MAX_IDX  = LIW'(MAX_DIGEST_BYTES);
  localparam logic [TAIL_W-1:0] MAX_TAIL = TAIL_W'(MAX_DIGEST_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic              start_err_r, start_err_nxt;
  logic              info_mis_r, info_mis_nxt;
  logic              dig_mis_r, dig_mis_nxt;
  logic [LIW-1:0]    load_idx_r, load_idx_nxt;

  logic [TAIL_W-1:0] plen, total;
  logic [TAIL_W-1:0] dig_idx, rd_diff;
  logic [7:0]        expect_byte;
  logic [2:0]        status;
  logic              is_msg;

  always_comb begin
    plen        = TAIL_W'(prefix_len(hash_kind));
    total       = plen + TAIL_W'(hash_bytes(hash_kind));
    dig_idx     = tail_r - plen;
    expect_byte = (dig_idx < MAX_TAIL) ? rd_data : 8'h00;
    is_msg      = fire && (item.cmd == CMD_MSG);

    phase_nxt     = phase_r;
    tail_nxt      = tail_r;
    start_err_nxt = start_err_r;
    info_mis_nxt  = info_mis_r;
    dig_mis_nxt   = dig_mis_r;
    load_idx_nxt  = load_idx_r;
    wr_en         = 1'b0;

    if (fire && (item.cmd == CMD_LOAD)) begin
      if (load_idx_r < MAX_IDX) begin
        wr_en        = 1'b1;
        load_idx_nxt = load_idx_r + 1'b1;
      end
      if (item.last) begin
        load_idx_nxt = '0;
      end
    end

    if (is_msg) begin
      case (phase_r)
        PH_FIRST, PH_TYPE: begin
          if ((phase_r == PH_FIRST) && (item.data == BYTE_ZERO)) begin
            phase_nxt = PH_TYPE;
          end else if ((item.data == BYTE_TYPE_1) || (item.data == BYTE_TYPE_2)) begin
            phase_nxt = PH_FILL;
          end else begin
            start_err_nxt = 1'b1;
            phase_nxt     = PH_BAD;
          end
        end
        PH_FILL: begin
          if (item.data == BYTE_ZERO) begin
            phase_nxt = PH_TAIL;
            tail_nxt  = '0;
          end
        end
        PH_TAIL: begin
          if (tail_r < plen) begin
            if (item.data != prefix_byte(hash_kind, tail_r[4:0])) begin
              info_mis_nxt = 1'b1;
            end
          end else if (tail_r < total) begin
            if (item.data != expect_byte) begin
              dig_mis_nxt = 1'b1;
            end
          end
          if (tail_r != TAIL_MAX) begin
            tail_nxt = tail_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (start_err_nxt || (phase_nxt == PH_TYPE)) begin
      status = ST_BAD_START;
    end else if (phase_nxt != PH_TAIL) begin
      status = ST_NO_END;
    end else if (tail_nxt != total) begin
      status = ST_LENGTH;
    end else if (info_mis_nxt) begin
      status = ST_INFO;
    end else if (dig_mis_nxt) begin
      status = ST_DIGEST;
    end else begin
      status = ST_OK;
    end

    // the last message byte returns the parser to its start
    if (is_msg && item.last) begin
      phase_nxt     = PH_FIRST;
      tail_nxt      = '0;
      start_err_nxt = 1'b0;
      info_mis_nxt  = 1'b0;
      dig_mis_nxt   = 1'b0;
    end

    // digest byte that the next item will compare against
    rd_diff = tail_nxt - plen;
  end

  assign wr_addr       = load_idx_r[AW-1:0];
  assign wr_data       = item.data;
  assign rd_addr       = rd_diff[AW-1:0];
  assign result.valid  = is_msg && item.last;
  assign result.status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      tail_r      <= '0;
      start_err_r <= 1'b0;
      info_mis_r  <= 1'b0;
      dig_mis_r   <= 1'b0;
      load_idx_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      tail_r      <= tail_nxt;
      start_err_r <= start_err_nxt;
      info_mis_r  <= info_mis_nxt;
      dig_mis_r   <= dig_mis_nxt;
      load_idx_r  <= load_idx_nxt;
    end
  end

endmodule

// ===== src/pkcs1_signature_digest_checker.sv =====
// ----------------------------------------------------------------------------
// pkcs1_signature_digest_checker
// PKCS#1 v1.5 signature block check against a loaded expected digest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_cmd, in_data, in_last
//  out_    | output    | out_valid/stall  | out_status
//  cfg_    | input     | cfg_valid/ready  | cfg_data (hash kind)
//
//  one byte accepted every cycle while in_stall is low; after the last message
//  byte is accepted, its status passes the input register, then the result register
//  the digest store read is issued on accept and used as the byte leaves s1_item_r
//  rst_n is synchronous; no clearing pass, the store holds garbage until loaded
//  out_stall holds the input only while a last message byte waits for a full
//  result register; all other bytes keep flowing
// ----------------------------------------------------------------------------
module pkcs1_signature_digest_checker
  import psdc_pkg::*;
#(
  parameter int MAX_DIGEST_BYTES = DEF_MAX_DIGEST_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int AW = $clog2(MAX_DIGEST_BYTES);

  logic          s1_valid_r, s1_valid_nxt;
  item_t         s1_item_r;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r;
  logic [1:0]    hash_kind_r;
  logic          byp_r;
  logic [7:0]    byp_data_r;

  logic          fire, in_acc, slot_free, needs_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data, dig_byte;
  result_t       result;

  assign slot_free  = !out_valid_r || !out_stall;
  assign needs_slot = (s1_item_r.cmd == CMD_MSG) && s1_item_r.last;
  assign fire       = s1_valid_r && (!needs_slot || slot_free);
  assign in_stall   = s1_valid_r && !fire;
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  // a load leaving the input register lands in the same cycle as the read
  assign dig_byte = byp_r ? byp_data_r : rd_data;

  psdc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DIGEST_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psdc_parse #(
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .hash_kind (hash_kind_r),
    .rd_data   (dig_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .result    (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (result.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hash_kind_r <= HASH_KIND_RST;
      byp_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hash_kind_r <= cfg_data;
      end
      if (in_acc) begin
        byp_r <= wr_en && (wr_addr == rd_addr) && (in_cmd == CMD_MSG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.cmd  <= in_cmd;
      s1_item_r.data <= in_data;
      s1_item_r.last <= in_last;
      byp_data_r     <= wr_data;
    end
    if (result.valid) begin
      status_r <= result.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  // a status is only produced when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> slot_free)
    else $error("status produced while result register is held");

  // input only stalls behind a waiting last message byte and a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && needs_slot && out_valid_r && out_stall))
    else $error("input stalled without a blocked status");

  // forwarded store data only ever serves a message byte
  a_bypass_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (byp_r && s1_valid_r) |-> (s1_item_r.cmd == CMD_MSG))
    else $error("store forwarding on a load item");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r <= ST_DIGEST))
    else $error("undefined status code");

endmodule

// ===== bench/pkcs1_signature_digest_checker_tb.sv =====
// ----------------------------------------------------------------------------
// pkcs1_signature_digest_checker_tb
// Streams digest loads and encoded signature blocks through the checker under
// random idling and back-pressure on both channels, and compares every status
// with a cycle-free prediction of the parser, over all four hash kinds.
// ----------------------------------------------------------------------------
module pkcs1_signature_digest_checker_tb;
  import psdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1800;
  localparam int RESULT_TARGET  = 60;
  localparam int PHASE_ITEMS    = 120;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // expected status per accepted message, from a byte-level parser model
  class status_scoreboard;
    logic [1:0]        hash_kind;
    phase_t            parse_st;
    logic [TAIL_W-1:0] tail_count;
    bit                start_err;
    bit                info_bad;
    bit                digest_bad;
    logic [7:0]        store [DEF_MAX_DIGEST_BYTES];
    logic [6:0]        load_idx;
    logic [7:0]        info_rom [4][19];
    logic [2:0]        expected_status [$];
    int                errors;
    int                results_seen;

    function new();
      info_rom = '{
        '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
          8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
          8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
        '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
          8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
        '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
          8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
      };
      hash_kind = HASH_KIND_RST;
      load_idx = '0;
      errors = 0;
      results_seen = 0;
      clear_parse();
    endfunction

    function int info_len(input logic [1:0] kind);
      return (kind == 2'd0) ? 15 : 19;
    endfunction

    function int hash_len(input logic [1:0] kind);
      int n;
      case (kind)
        2'd0:    n = 20;
        2'd1:    n = 32;
        2'd2:    n = 48;
        default: n = 64;
      endcase
      return n;
    endfunction

    function void clear_parse();
      parse_st = PH_FIRST;
      tail_count = '0;
      start_err = 1'b0;
      info_bad = 1'b0;
      digest_bad = 1'b0;
    endfunction

    function void take_type(input logic [7:0] b);
      if (b == BYTE_TYPE_1 || b == BYTE_TYPE_2) begin
        parse_st = PH_FILL;
      end else begin
        start_err = 1'b1;
        parse_st = PH_BAD;
      end
    endfunction

    function void take_tail(input logic [7:0] b);
      int plen;
      int dlen;
      int idx;
      logic [7:0] want;
      plen = info_len(hash_kind);
      dlen = hash_len(hash_kind);
      if (tail_count < plen) begin
        if (b != info_rom[hash_kind][tail_count]) info_bad = 1'b1;
      end else if (tail_count < plen + dlen) begin
        idx = tail_count - plen;
        want = (idx < DEF_MAX_DIGEST_BYTES) ? store[idx] : 8'h00;
        if (b != want) digest_bad = 1'b1;
      end
      if (tail_count < TAIL_MAX) tail_count = tail_count + 1'b1;
    endfunction

    function void absorb_byte(input logic cmd, input logic [7:0] b, input logic last);
      logic [2:0] st;
      if (cmd == CMD_LOAD) begin
        // extra load bytes are dropped, index sticks at the end
        if (load_idx < DEF_MAX_DIGEST_BYTES) begin
          store[load_idx] = b;
          load_idx = load_idx + 1'b1;
        end
        if (last) load_idx = '0;
        return;
      end
      case (parse_st)
        PH_FIRST: begin
          if (b == BYTE_ZERO) parse_st = PH_TYPE;
          else take_type(b);
        end
        PH_TYPE: take_type(b);
        PH_FILL: begin
          if (b == BYTE_ZERO) begin
            parse_st = PH_TAIL;
            tail_count = '0;
          end
        end
        PH_TAIL: take_tail(b);
        default: ;
      endcase
      if (!last) return;
      if (start_err || parse_st == PH_TYPE) st = ST_BAD_START;
      else if (parse_st != PH_TAIL) st = ST_NO_END;
      else if (tail_count != info_len(hash_kind) + hash_len(hash_kind)) st = ST_LENGTH;
      else if (info_bad) st = ST_INFO;
      else if (digest_bad) st = ST_DIGEST;
      else st = ST_OK;
      expected_status.push_back(st);
      clear_parse();
    endfunction

    function void check_status(input logic [2:0] actual);
      logic [2:0] want;
      results_seen++;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected status %0d, none expected", $time, actual);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (actual !== want) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_cmd;
  logic [7:0] in_data;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  status_scoreboard sb = new();
  logic [7:0] msg_bytes [$];
  int items_sent = 0;
  int tx_idle_pct = 32;
  int rx_idle_pct = 32;
  int hold_req = 0;
  int quiet_cycles = 0;

  pkcs1_signature_digest_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_data    (in_data),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_status(out_status);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic cmd, input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data <= b;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_byte(cmd, b, last);
    items_sent++;
  endtask

  // sends msg_bytes as one message, optionally with digest loads mixed in
  task automatic send_msg(input bit mix_loads);
    int i;
    for (i = 0; i < msg_bytes.size(); i++) begin
      if (mix_loads && $urandom_range(99) < 3) begin
        send_byte(CMD_LOAD, 8'($urandom_range(255)), ($urandom_range(3) == 0));
      end
      send_byte(CMD_MSG, msg_bytes[i], (i == msg_bytes.size() - 1));
    end
  endtask

  task automatic load_digest(input int n, input bit with_last);
    int i;
    for (i = 0; i < n; i++) begin
      send_byte(CMD_LOAD, 8'($urandom_range(255)), with_last && (i == n - 1));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hash_kind(input logic [1:0] kind);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= kind;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.hash_kind = kind;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] marker_biased_byte();
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = BYTE_ZERO;
      1:       b = $urandom_range(1) ? BYTE_TYPE_2 : BYTE_TYPE_1;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic build_noise();
    msg_bytes.delete();
    repeat ($urandom_range(1, 6)) msg_bytes.push_back(marker_biased_byte());
  endtask

  // well-formed block for the current hash kind and store, with optional faults
  task automatic build_signature(input bit allow_faults);
    int plen;
    int dlen;
    int n;
    int te;
    int ts;
    int i;
    logic [1:0] k;
    k = sb.hash_kind;
    plen = sb.info_len(k);
    dlen = sb.hash_len(k);
    msg_bytes.delete();
    if ($urandom_range(3) != 0) msg_bytes.push_back(BYTE_ZERO);
    msg_bytes.push_back($urandom_range(1) ? BYTE_TYPE_2 : BYTE_TYPE_1);
    n = $urandom_range(0, 10);
    repeat (n) msg_bytes.push_back(($urandom_range(3) == 0) ? 8'hff : 8'($urandom_range(1, 255)));
    te = msg_bytes.size();
    msg_bytes.push_back(BYTE_ZERO);
    ts = msg_bytes.size();
    for (i = 0; i < plen; i++) msg_bytes.push_back(sb.info_rom[k][i]);
    for (i = 0; i < dlen; i++) msg_bytes.push_back(sb.store[i]);
    if (!allow_faults) return;
    if ($urandom_range(99) < 12) msg_bytes[ts + $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(99) < 12) begin
      msg_bytes[ts + plen + $urandom_range(0, dlen - 1)] ^= 8'($urandom_range(1, 255));
    end
    if ($urandom_range(99) < 8) begin
      msg_bytes[te - n - 1] = ($urandom_range(3) == 0) ? BYTE_ZERO : 8'($urandom_range(3, 255));
    end
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) void'(msg_bytes.pop_back());
    end else if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(255)));
    end
    // no end marker: cut the block right before it
    if ($urandom_range(99) < 6) begin
      while (msg_bytes.size() > te) void'(msg_bytes.pop_back());
    end
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      build_signature(1'b1);
      send_msg(1'b1);
    end else if (r < 80) begin
      build_noise();
      send_msg(1'b1);
    end else if (r < 92) begin
      load_digest($urandom_range(1, 70), ($urandom_range(9) != 0));
    end else begin
      load_digest(sb.hash_len(sb.hash_kind), 1'b1);
      build_signature(1'b0);
      send_msg(1'b0);
    end
  endtask

  initial begin
    int phase_no;
    int phase_end;
    logic [1:0] kind;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_data = 8'h00;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 2'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole store so no tail byte ever reads an unwritten entry
    load_digest(DEF_MAX_DIGEST_BYTES, 1'b1);

    // directed corner cases at the reset hash kind
    msg_bytes = '{BYTE_ZERO};                         // lone leading zero
    send_msg(1'b0);
    msg_bytes = '{8'hff};                             // bad type byte
    send_msg(1'b0);
    msg_bytes = '{8'h07, BYTE_ZERO, BYTE_TYPE_1, 8'h80}; // bytes after bad marker
    send_msg(1'b0);
    msg_bytes = '{BYTE_ZERO, BYTE_ZERO};              // zero where type is due
    send_msg(1'b0);
    msg_bytes = '{BYTE_TYPE_1};                       // type byte as last
    send_msg(1'b0);
    msg_bytes = '{BYTE_ZERO, BYTE_TYPE_2};
    send_msg(1'b0);
    msg_bytes = '{BYTE_TYPE_1, 8'hff, 8'h01};         // fill as last
    send_msg(1'b0);
    msg_bytes = '{BYTE_TYPE_2, BYTE_ZERO};            // empty tail
    send_msg(1'b0);
    send_byte(CMD_LOAD, 8'h00, 1'b1);
    send_byte(CMD_LOAD, 8'hff, 1'b1);
    load_digest(DEF_MAX_DIGEST_BYTES, 1'b1);

    phase_no = 0;
    while (items_sent < ITEM_TARGET || sb.results_seen < RESULT_TARGET) begin
      case (phase_no)
        0:       kind = 2'd0;
        1:       kind = 2'd3;
        2:       kind = 2'd2;
        3:       kind = 2'd1;
        default: kind = 2'($urandom_range(3));
      endcase
      write_hash_kind(kind);
      tx_idle_pct = 32;
      rx_idle_pct = 32;
      if (phase_no == 1) begin
        // results pile up behind a long receiver hold-off
        hold_req = 1;
        repeat (12) begin
          build_noise();
          send_msg(1'b0);
        end
      end
      if (phase_no == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase_no == 3) begin
        // tail far past the saturation point of the tail counter
        msg_bytes = '{BYTE_TYPE_1, BYTE_ZERO};
        repeat (1100) msg_bytes.push_back(8'($urandom_range(255)));
        send_msg(1'b0);
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_step();
      phase_no++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
